// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/tskl_pkg.sv =====
// ----------------------------------------------------------------------------
// tskl_pkg
// Types, constants and the tanh table of the soft-knee limiter.
// ----------------------------------------------------------------------------
package tskl_pkg;

  // Item widths
  localparam int SAMPLE_W = 16;
  localparam int CEIL_W   = 15;

  // Knee = 0.85 in Q0.15
  localparam logic [CEIL_W-1:0] KNEE_Q15 = 15'd27853;

  // tanh table geometry; the ratio is Q2.16 and stays below 4.0
  localparam int TANH_DEPTH = 256;
  localparam int TANH_IDX_W = $clog2(TANH_DEPTH);
  localparam int RATIO_W    = 18;
  localparam int FRAC_W     = 16;
  localparam int FRAC_PAD   = FRAC_W - (RATIO_W - TANH_IDX_W);

  // Shared multiply-add unit
  localparam int MUL_W = 17;
  localparam int ACC_W = 2 * MUL_W;

  localparam logic [MUL_W-1:0] TANH_ONE = 17'd32768;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_IDX_CEILING = 1'b0;
  localparam logic REG_IDX_ENABLE  = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [SAMPLE_W-1:0]        peak_level;
    logic                       block_end;
  } out_item_t;

  typedef logic [TANH_DEPTH-1:0][15:0] tanh_rom_t;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // Entry k = round(32768 * tanh(4k/DEPTH)), built in Q30 as (1-e)/(1+e)
  // with e = exp(-8k/DEPTH): a 4th-order series squared eight times.
  // Evaluated at elaboration only.
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] u;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    rom = '0;
    for (int k = 0; k < TANH_DEPTH; k++) begin
      u  = (64'(k) << 25) / TANH_DEPTH;
      t2 = (u * u) >> 30;
      t3 = (t2 * u) >> 30;
      t4 = (t3 * u) >> 30;
      e  = ONE_Q30 - u + t2 / 2 - t3 / 6 + t4 / 24;
      for (int i = 0; i < 8; i++) begin
        e = (e * e) >> 30;
      end
      den = ONE_Q30 + e;
      num = ((ONE_Q30 - e) << 15) + (den >> 1);
      // rounded quotient by long division
      rem = '0;
      quo = '0;
      for (int b = 47; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[b] = 1'b1;
        end
      end
      if (quo > 64'd65535) begin
        quo = 64'd65535;
      end
      rom[k] = quo[15:0];
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

// ===== rtl/tanh_soft_knee_limiter.sv =====
// ----------------------------------------------------------------------------
// tanh_soft_knee_limiter
// Soft-knee audio limiter: magnitudes above 0.85 x ceiling are shaped by an
// interpolated tanh into the remaining headroom; tracks the per-block peak.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   in_data_i  (sample_in, block_last)
//  out       source     out_valid_o / out_stall_i out_data_o (sample_out, peak_level,
//                                                             block_end)
//  cfg       APB slave  psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  A limited item runs the knee and compare steps, the restoring divide of excess
//  by headroom, table read, interpolation and scaling; one at or below the knee
//  skips to the final step, a saturated one to scaling, one with limiting off
//  straight to the final step. The next item is taken the cycle after the output
//  register is loaded. One multiply-add unit serves the knee, the interpolation and
//  the scaling. in_stall_o is high while an item is in work; a held output stalls
//  only the final step. Reset: ceiling 32767, limiting on, block peak cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tanh_soft_knee_limiter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tskl_pkg::in_item_t                   in_data_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tskl_pkg::out_item_t                  out_data_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tskl_pkg::ADDR_W-1:0]          paddr,
  input  logic [tskl_pkg::DATA_W-1:0]          pwdata,
  output logic [tskl_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  import tskl_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_KNEE = 10'b00_0000_0010,
    ST_CMP  = 10'b00_0000_0100,
    ST_SEL  = 10'b00_0000_1000,
    ST_DIV  = 10'b00_0001_0000,
    ST_ROM  = 10'b00_0010_0000,
    ST_MUL1 = 10'b00_0100_0000,
    ST_MUL2 = 10'b00_1000_0000,
    ST_SHP  = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CEIL_W-1:0] ceiling_q;
  logic              enable_q;
  logic              cfg_wr;

  // item registers
  logic [SAMPLE_W-1:0] raw_q, raw_d;
  logic [SAMPLE_W-1:0] ax_q, ax_d;
  logic [SAMPLE_W-1:0] peak_q, peak_d;
  logic [SAMPLE_W-1:0] item_peak_q, item_peak_d;
  logic                last_q, last_d;
  logic                pass_q, pass_d;
  logic [SAMPLE_W-1:0] knee_q, knee_d;
  logic [SAMPLE_W-1:0] head_q, head_d;
  logic [SAMPLE_W-1:0] ex_q, ex_d;

  // divider
  logic [SAMPLE_W-1:0] rem_q, rem_d;
  logic [RATIO_W-1:0]  nsh_q, nsh_d;
  logic [RATIO_W-1:0]  quo_q, quo_d;
  logic [4:0]          cnt_q, cnt_d;

  // interpolation and shared multiply-add
  logic [MUL_W-1:0] lo_q, lo_d;
  logic [MUL_W-1:0] hi_q, hi_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [ACC_W-1:0] mul_c, mul_res;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  // combinational helpers
  logic                  in_fire;
  logic [SAMPLE_W-1:0]   ax_in;
  logic [SAMPLE_W-1:0]   peak_new;
  logic [SAMPLE_W-1:0]   knee_c;
  logic [SAMPLE_W-1:0]   div_trial;
  logic                  div_ge;
  logic [TANH_IDX_W-1:0] idx;
  logic [TANH_IDX_W-1:0] idx_nxt;
  logic [FRAC_W-1:0]     frac;
  logic [SAMPLE_W-1:0]   shaped;
  logic [SAMPLE_W-1:0]   result;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= '1;
      enable_q  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IDX_CEILING: ceiling_q <= pwdata[CEIL_W-1:0];
        REG_IDX_ENABLE:  enable_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_CEILING: prdata = DATA_W'(ceiling_q);
      REG_IDX_ENABLE:  prdata = DATA_W'(enable_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;

  // magnitude; the most negative sample gives 32768
  assign ax_in    = in_data_i.sample_in[SAMPLE_W-1] ? (~in_data_i.sample_in + 1'b1)
                                                    : in_data_i.sample_in;
  assign peak_new = (ax_in > peak_q) ? ax_in : peak_q;

  // --------------------------------------------------------------------------
  // Shared multiply-add unit
  // --------------------------------------------------------------------------
  assign mul_res = ACC_W'(mul_a) * ACC_W'(mul_b) + mul_c;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    case (state_q)
      ST_KNEE: begin
        mul_a = MUL_W'(ceiling_q);
        mul_b = MUL_W'(KNEE_Q15);
        mul_c = ACC_W'(16384);
      end
      ST_MUL1: begin
        mul_a = lo_q;
        mul_b = (MUL_W'(1) << FRAC_W) - MUL_W'(frac);
        mul_c = ACC_W'(32768);
      end
      ST_MUL2: begin
        mul_a = hi_q;
        mul_b = MUL_W'(frac);
        mul_c = acc_q;
      end
      ST_SHP: begin
        mul_a = MUL_W'(head_q);
        mul_b = acc_q[FRAC_W +: MUL_W];
        mul_c = ACC_W'(16384);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign knee_c = SAMPLE_W'(acc_q >> 15);

  // one restoring divide step
  assign div_trial = {rem_q[SAMPLE_W-2:0], nsh_q[RATIO_W-1]};
  assign div_ge    = (div_trial >= head_q);

  // table position from the Q2.16 ratio
  assign idx     = quo_q[RATIO_W-1 -: TANH_IDX_W];
  assign idx_nxt = idx + 1'b1;
  assign frac    = {quo_q[RATIO_W-TANH_IDX_W-1:0], FRAC_PAD'(0)};

  assign shaped = knee_q + SAMPLE_W'(acc_q >> 15);
  assign result = pass_q ? raw_q
                : (raw_q[SAMPLE_W-1] ? (~shaped + 1'b1) : shaped);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    raw_d       = raw_q;
    ax_d        = ax_q;
    peak_d      = peak_q;
    item_peak_d = item_peak_q;
    last_d      = last_q;
    pass_d      = pass_q;
    knee_d      = knee_q;
    head_d      = head_q;
    ex_d        = ex_q;
    rem_d       = rem_q;
    nsh_d       = nsh_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          raw_d  = in_data_i.sample_in;
          ax_d   = ax_in;
          last_d = in_data_i.block_last;
          pass_d = 1'b1;
          // peak is reported with the last item and restarts after it
          if (in_data_i.block_last) begin
            item_peak_d = peak_new;
            peak_d      = '0;
          end else begin
            item_peak_d = '0;
            peak_d      = peak_new;
          end
          state_d = enable_q ? ST_KNEE : ST_FIN;
        end
      end
      ST_KNEE: begin
        acc_d   = mul_res;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        knee_d  = knee_c;
        head_d  = SAMPLE_W'(ceiling_q) - knee_c;
        ex_d    = ax_q - knee_c;
        pass_d  = (ax_q <= knee_c);
        state_d = ST_SEL;
      end
      ST_SEL: begin
        if (pass_q) begin
          state_d = ST_FIN;
        end else if ((SAMPLE_W + 2)'(ex_q) >= {head_q, 2'b00}) begin
          // ratio at or past 4.0, or no headroom: tanh is one
          acc_d   = ACC_W'(TANH_ONE) << FRAC_W;
          state_d = ST_SHP;
        end else begin
          rem_d   = ex_q >> 2;
          nsh_d   = {ex_q[1:0], (RATIO_W - 2)'(0)};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = div_ge ? (div_trial - head_q) : div_trial;
        quo_d = {quo_q[RATIO_W-2:0], div_ge};
        nsh_d = nsh_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(RATIO_W - 1)) begin
          state_d = ST_ROM;
        end
      end
      ST_ROM: begin
        lo_d = MUL_W'(TANH_ROM[idx]);
        hi_d = (idx == TANH_IDX_W'(TANH_DEPTH - 1)) ? TANH_ONE
                                                     : MUL_W'(TANH_ROM[idx_nxt]);
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d   = mul_res;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        acc_d   = mul_res;
        state_d = ST_SHP;
      end
      ST_SHP: begin
        acc_d   = mul_res;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // wait here while the previous item is still held downstream
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_data_d.sample_out = result;
          out_data_d.peak_level = item_peak_q;
          out_data_d.block_end  = last_q;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    raw_q       <= raw_d;
    ax_q        <= ax_d;
    item_peak_q <= item_peak_d;
    last_q      <= last_d;
    pass_q      <= pass_d;
    knee_q      <= knee_d;
    head_q      <= head_d;
    ex_q        <= ex_d;
    rem_q       <= rem_d;
    nsh_q       <= nsh_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    acc_q       <= acc_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPLY(a_div_rem_below_head, clk_i, rst_ni, state_q == ST_DIV, rem_q < head_q, "divide remainder not below headroom")
  `ASSERT_IMPLY(a_shaped_within_ceiling, clk_i, rst_ni, (state_q == ST_FIN) && !pass_q, shaped <= SAMPLE_W'(ceiling_q), "shaped magnitude above ceiling")
  `ASSERT_ALWAYS(a_out_loaded_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "output valid raised outside final step")

endmodule
